// File: rtl/lzrm_pkg.sv
// Package for the LZ run-and-match decoder: sizes, codes and shared types.
// Used by lzrm_addr_unit, the decoder core and the testbench; depends on nothing.
package lzrm_pkg;

  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned MAX_OUTPUT = 65536;
  localparam int unsigned CNT_W      = $clog2(MAX_OUTPUT + 1);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned TUSER_W    = 4;

  localparam logic [BYTE_W-1:0] LIT_TOKEN_MAX = 8'h0F;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_LITERAL,
    PH_DISTANCE
  } phase_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_FAR  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_TRUNC    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COPY_RD,
    S_COPY_WR
  } seq_e;

  typedef struct packed {
    logic [HIST_AW-1:0] rd_addr;
    logic               too_far;
    logic               full;
    logic               near_full;
  } addr_info_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid_byte;
    logic              last;
    status_e           status;
    logic              stream_end;
  } result_t;

endpackage

// File: rtl/lzrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lzrm_addr_unit.sv
// Shared address and bound unit: history read address and count compares.
// Depends on lzrm_pkg.
module lzrm_addr_unit (
  input  logic [lzrm_pkg::CNT_W-1:0]  produced_i,
  input  logic [lzrm_pkg::DIST_W-1:0] dist_i,
  output lzrm_pkg::addr_info_t        info_o
);
  import lzrm_pkg::*;

  always_comb begin
    info_o.rd_addr   = produced_i[HIST_AW-1:0] - HIST_AW'(dist_i);
    info_o.too_far   = CNT_W'(dist_i) > produced_i;
    info_o.full      = produced_i >= CNT_W'(MAX_OUTPUT);
    info_o.near_full = produced_i == CNT_W'(MAX_OUTPUT - 1);
  end

endmodule

// File: rtl/lz_run_and_match_decoder_core.sv
// Top level of the LZ run-and-match decoder: sequencer, decode state, output stage.
// Depends on lzrm_pkg, lzrm_ram and lzrm_addr_unit.
//
// Decodes an LZ77-style byte stream with a 4 KiB history, one packed byte per
// input beat, and emits decoded bytes one per output beat. Each input byte is
// accepted in S_IDLE and evaluated in S_EVAL; a distance byte that starts a
// copy of L bytes then passes through S_COPY_RD and S_COPY_WR for each copied
// byte, since each copied byte needs one history read and one write through
// the single RAM port pair before the next, overlapping byte can be read. A
// stalled output holds the sequencer. Status-only beats carry valid_byte 0.
// The history needs no clearing after reset.
module lz_run_and_match_decoder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lzrm_pkg::BYTE_W-1:0]     s_axis_tdata_i,  // [7:0] in_byte
  input  logic                            s_axis_tlast_i,  // in_last
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lzrm_pkg::BYTE_W-1:0]     m_axis_tdata_o,  // [7:0] out_byte
  output logic                            m_axis_tlast_o,  // out_last
  output logic [lzrm_pkg::TUSER_W-1:0]    m_axis_tuser_o   // [0] out_valid_byte,
                                                           // [2:1] out_status,
                                                           // [3] out_stream_end
);
  import lzrm_pkg::*;

  seq_e               state_q, state_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic               last_q, last_d;
  logic [CNT_W-1:0]   produced_q, produced_d;
  phase_e             phase_q, phase_d;
  logic [LEN_W-1:0]   lit_rem_q, lit_rem_d;
  logic [LEN_W-1:0]   copy_len_q, copy_len_d;
  logic [3:0]         nib_q, nib_d;
  logic               stopped_q, stopped_d;
  logic [DIST_W-1:0]  dist_q, dist_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  result_t            out_q;
  logic               out_valid_q, out_valid_d;

  result_t            res;
  addr_info_t         info;
  logic [DIST_W-1:0]  dist_sel;
  logic [BYTE_W-1:0]  rdata;
  logic [BYTE_W-1:0]  wdata;
  logic               s_fire;
  logic               out_free;
  logic               emit_req;
  logic               emit;
  logic               adv;
  logic               we;
  logic               re;
  logic               eval_copy;
  logic               copy_final;
  logic               stop;
  logic               ended;
  logic               rearm;
  status_e            stop_status;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign adv             = !emit_req || out_free;
  assign emit            = emit_req && out_free;
  assign dist_sel        = (state_q == S_EVAL) ? {nib_q, byte_q} : dist_q;

  lzrm_addr_unit u_addr (
    .produced_i (produced_q),
    .dist_i     (dist_sel),
    .info_o     (info)
  );

  lzrm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (produced_q[HIST_AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (info.rd_addr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (adv) state_d = eval_copy ? S_COPY_RD : S_IDLE;
      end
      S_COPY_RD: begin
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        if (adv) state_d = copy_final ? S_IDLE : S_COPY_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    byte_d      = byte_q;
    last_d      = last_q;
    produced_d  = produced_q;
    phase_d     = phase_q;
    lit_rem_d   = lit_rem_q;
    copy_len_d  = copy_len_q;
    nib_d       = nib_q;
    stopped_d   = stopped_q;
    dist_d      = dist_q;
    rem_d       = rem_q;
    res         = '0;
    emit_req    = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    wdata       = byte_q;
    eval_copy   = 1'b0;
    copy_final  = 1'b0;
    stop        = 1'b0;
    ended       = 1'b0;
    rearm       = 1'b0;
    stop_status = STAT_OK;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          byte_d = s_axis_tdata_i;
          last_d = s_axis_tlast_i;
        end
      end
      S_EVAL: begin
        if (stopped_q) begin
          rearm = last_q;
        end else begin
          unique case (phase_q)
            PH_LITERAL: begin
              if (info.full) begin
                stop        = 1'b1;
                stop_status = STAT_FULL;
              end else begin
                we             = 1'b1;
                produced_d     = produced_q + CNT_W'(1);
                res.data       = byte_q;
                res.valid_byte = 1'b1;
                emit_req       = 1'b1;
                if (lit_rem_q != '0) lit_rem_d = lit_rem_q - LEN_W'(1);
                if (lit_rem_q <= LEN_W'(1)) phase_d = PH_TOKEN;
              end
            end
            PH_DISTANCE: begin
              phase_d    = PH_TOKEN;
              copy_len_d = '0;
              nib_d      = '0;
              if (info.too_far) begin
                stop        = 1'b1;
                stop_status = STAT_TOO_FAR;
              end else if (info.full) begin
                stop        = 1'b1;
                stop_status = STAT_FULL;
              end else begin
                eval_copy = 1'b1;
                dist_d    = dist_sel;
                rem_d     = copy_len_q;
              end
            end
            default: begin
              phase_d = PH_TOKEN;
              if (info.full) begin
                stop        = 1'b1;
                stop_status = STAT_FULL;
              end else if (byte_q <= LIT_TOKEN_MAX) begin
                lit_rem_d = LEN_W'(byte_q[3:0]) + LEN_W'(1);
                phase_d   = PH_LITERAL;
              end else begin
                copy_len_d = LEN_W'(byte_q[7:4]) + LEN_W'(1);
                nib_d      = byte_q[3:0];
                phase_d    = PH_DISTANCE;
              end
            end
          endcase
          if (!eval_copy) begin
            ended = stop || last_q;
            if (ended || emit_req) begin
              emit_req       = 1'b1;
              res.last       = 1'b1;
              res.stream_end = ended;
              if (stop) begin
                res.status = stop_status;
              end else if (last_q && phase_d != PH_TOKEN) begin
                res.status = STAT_TRUNC;
              end else begin
                res.status = STAT_OK;
              end
            end
            stopped_d = stop;
            rearm     = last_q;
          end
        end
      end
      S_COPY_RD: begin
        re = 1'b1;
      end
      S_COPY_WR: begin
        emit_req       = 1'b1;
        wdata          = (dist_q == '0) ? '0 : rdata;
        we             = 1'b1;
        produced_d     = produced_q + CNT_W'(1);
        rem_d          = rem_q - LEN_W'(1);
        res.data       = wdata;
        res.valid_byte = 1'b1;
        stop           = (rem_q > LEN_W'(1)) && info.near_full;
        copy_final     = (rem_q <= LEN_W'(1)) || info.near_full;
        if (copy_final) begin
          ended          = stop || last_q;
          res.last       = 1'b1;
          res.stream_end = ended;
          res.status     = stop ? STAT_FULL : STAT_OK;
          stopped_d      = stop;
          rearm          = last_q;
        end
      end
      default: begin
        rearm = 1'b0;
      end
    endcase

    if (rearm) begin
      produced_d = '0;
      phase_d    = PH_TOKEN;
      lit_rem_d  = '0;
      copy_len_d = '0;
      nib_d      = '0;
      stopped_d  = 1'b0;
    end

    if (!adv) begin
      we = 1'b0;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      produced_q  <= '0;
      phase_q     <= PH_TOKEN;
      lit_rem_q   <= '0;
      copy_len_q  <= '0;
      nib_q       <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        produced_q <= produced_d;
        phase_q    <= phase_d;
        lit_rem_q  <= lit_rem_d;
        copy_len_q <= copy_len_d;
        nib_q      <= nib_d;
        stopped_q  <= stopped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    if (adv) begin
      dist_q <= dist_d;
      rem_q  <= rem_d;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.data;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tuser_o  = {out_q.stream_end, out_q.status, out_q.valid_byte};

endmodule

// File: tb/tb.sv
// Testbench for lz_run_and_match_decoder_core: drives packed LZ bytes and checks decoded beats.
// Holds a predicting scoreboard class and stream driver tasks; depends on lzrm_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import lzrm_pkg::*;

  class lz_decode_scoreboard;
    logic [BYTE_W-1:0] history [HIST_DEPTH];
    logic [CNT_W-1:0]  produced;
    phase_e            phase;
    int unsigned       lit_left;
    int unsigned       copy_len;
    logic [3:0]        dist_hi;
    bit                stopped;
    result_t           step_q[$];
    result_t           decoded_q[$];
    int                mismatches;
    int                live_bytes;

    function new();
      rearm();
      mismatches = 0;
      live_bytes = 0;
    endfunction

    function void rearm();
      produced = '0;
      phase    = PH_TOKEN;
      lit_left = 0;
      copy_len = 0;
      dist_hi  = '0;
      stopped  = 1'b0;
    endfunction

    function result_t beat_of(logic [BYTE_W-1:0] v, logic vb);
      result_t r;
      r.data       = v;
      r.valid_byte = vb;
      r.last       = 1'b0;
      r.status     = STAT_OK;
      r.stream_end = 1'b0;
      return r;
    endfunction

    function void emit(logic [BYTE_W-1:0] v);
      history[produced[HIST_AW-1:0]] = v;
      produced++;
      step_q.push_back(beat_of(v, 1'b1));
    endfunction

    function void note_packed_byte(logic [BYTE_W-1:0] b, logic last);
      status_e           st;
      logic [DIST_W-1:0] dist_v;
      logic [BYTE_W-1:0] v;
      bit                ended;
      result_t           r;
      int unsigned       k;
      st    = STAT_OK;
      ended = 1'b0;
      step_q.delete();
      if (stopped) begin
        if (last) rearm();
        return;
      end
      live_bytes++;
      case (phase)
        PH_LITERAL: begin
          if (produced >= MAX_OUTPUT) begin
            stopped = 1'b1;
            st      = STAT_FULL;
          end else begin
            emit(b);
            if (lit_left > 0) lit_left--;
            if (lit_left == 0) phase = PH_TOKEN;
          end
        end
        PH_DISTANCE: begin
          dist_v = {dist_hi, b};
          phase  = PH_TOKEN;
          if (dist_v > produced) begin
            stopped = 1'b1;
            st      = STAT_TOO_FAR;
          end else begin
            for (k = 0; k < copy_len; k++) begin
              if (produced >= MAX_OUTPUT) begin
                stopped = 1'b1;
                st      = STAT_FULL;
                break;
              end
              v = (dist_v == 0) ? '0 : history[(produced - dist_v) % HIST_DEPTH];
              emit(v);
            end
          end
          copy_len = 0;
          dist_hi  = '0;
        end
        default: begin
          phase = PH_TOKEN;
          if (produced >= MAX_OUTPUT) begin
            stopped = 1'b1;
            st      = STAT_FULL;
          end else if (b <= LIT_TOKEN_MAX) begin
            lit_left = b + 1;
            phase    = PH_LITERAL;
          end else begin
            copy_len = b[7:4] + 1;
            dist_hi  = b[3:0];
            phase    = PH_DISTANCE;
          end
        end
      endcase
      if (stopped) begin
        ended = 1'b1;
      end else if (last) begin
        ended = 1'b1;
        st    = (phase != PH_TOKEN) ? STAT_TRUNC : STAT_OK;
      end
      if (ended) begin
        if (step_q.size() == 0) step_q.push_back(beat_of('0, 1'b0));
        r            = step_q.pop_back();
        r.last       = 1'b1;
        r.status     = st;
        r.stream_end = 1'b1;
        step_q.push_back(r);
        if (last) rearm();
      end else if (step_q.size() > 0) begin
        r      = step_q.pop_back();
        r.last = 1'b1;
        step_q.push_back(r);
      end
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: want %h vb=%b l=%b st=%0d e=%b, got %h vb=%b l=%b st=%0d e=%b",
                 $time, what, want.data, want.valid_byte, want.last, want.status, want.stream_end,
                 got.data, got.valid_byte, got.last, got.status, got.stream_end);
      end
    endfunction

    function void check_decoded(result_t got);
      result_t want;
      if (decoded_q.size() == 0) begin
        report("unexpected beat", beat_of('0, 1'b0), got);
        return;
      end
      want = decoded_q.pop_front();
      if (got.data !== want.data || got.valid_byte !== want.valid_byte ||
          got.last !== want.last || got.status !== want.status ||
          got.stream_end !== want.stream_end) begin
        report("beat mismatch", want, got);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                s_tvalid;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [BYTE_W-1:0]   m_tdata;
  logic                m_tlast;
  logic [TUSER_W-1:0]  m_tuser;

  lz_decode_scoreboard board;
  int                  gap_max;
  int                  stall_pct;
  int                  burst_left;
  int                  stall_left = 0;

  lz_run_and_match_decoder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      board.check_decoded(result_t'{data: m_tdata, valid_byte: m_tuser[0], last: m_tlast,
                                    status: status_e'(m_tuser[2:1]), stream_end: m_tuser[3]});
    end
  end

  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.note_packed_byte(b, last);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (board.decoded_q.size() != 0);
    burst_left = 0;
  endtask

  task automatic send_literals(input int n, input bit last);
    int i;
    send_beat(8'(n - 1), 1'b0);
    for (i = 0; i < n; i++) send_beat(8'($urandom_range(0, 255)), last && (i == n - 1));
  endtask

  task automatic send_copy(input int len, input int dist_v, input bit last);
    send_beat({4'(len - 1), 4'(dist_v >> 8)}, 1'b0);
    send_beat(8'(dist_v), last);
  endtask

  task automatic directed_beats();
    gap_max   = 0;
    stall_pct = 0;
    send_beat(8'h01, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_copy(16, 2, 1'b0);
    send_copy(2, 0, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hA5, 1'b1);
    gap_max   = 3;
    stall_pct = 30;
    send_beat(8'h1F, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h33, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h05, 1'b1);
    send_beat(8'h20, 1'b1);
    send_beat(8'h02, 1'b0);
    send_beat(8'h11, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_copy(3, 1, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h42, 1'b1);
  endtask

  task automatic random_module();
    int tokens, t, kind, len, dist_v, est;
    bit fin;
    tokens = $urandom_range(1, 6);
    est    = 0;
    case ($urandom_range(0, 2))
      0:       gap_max = 0;
      1:       gap_max = 2;
      default: gap_max = 6;
    endcase
    case ($urandom_range(0, 2))
      0:       stall_pct = 0;
      1:       stall_pct = 25;
      default: stall_pct = 60;
    endcase
    for (t = 0; t < tokens; t++) begin
      fin  = (t == tokens - 1);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(1, 16);
        send_literals(len, fin);
        est += len;
      end else if (kind < 88) begin
        len  = $urandom_range(2, 16);
        kind = $urandom_range(0, 99);
        if (est == 0 || kind < 8) dist_v = 0;
        else if (kind < 14) dist_v = $urandom_range(est + 1, 4095);
        else dist_v = $urandom_range(1, est);
        send_copy(len, dist_v, fin);
        if (dist_v > est) begin
          if (!fin) begin
            repeat ($urandom_range(0, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1);
          end
          return;
        end
        est += len;
      end else begin
        repeat ($urandom_range(0, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
    end
  endtask

  initial begin
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    rst_n      = 1'b0;
    gap_max    = 3;
    stall_pct  = 30;
    burst_left = 0;
    board      = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_beats();
    drain();
    while (board.live_bytes < 150) random_module();
    drain();
    repeat (40) @(posedge clk);

    if (board.mismatches == 0 && board.decoded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lzrm_pkg.sv
rtl/lzrm_ram.sv
rtl/lzrm_addr_unit.sv
rtl/lz_run_and_match_decoder_core.sv
tb/tb.sv
